/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The antecedent implies the consequent at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/pngv_pkg.sv */
// ---------------------------------------------------------------------------
// Packed nibble GEMV package
// Field widths, register indexes, pipeline types and the nibble decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pngv_pkg;

    localparam int INDEX_W     = 13;
    localparam int ACT_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int ROW_W       = 14;
    localparam int SUM_W       = 25;
    localparam int BLOCKS_W    = 12;
    localparam int GROUPS_W    = 13;
    localparam int BLOCK_CNT_W = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int BLOCK_LIMIT = 2048;
    localparam int NIB_W       = 5;
    localparam int PROD_W      = ACT_W + NIB_W;
    localparam int PAIR_W      = PROD_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_BLOCKS  = 2'd0,
        CFG_OUTPUT_GROUPS = 2'd1,
        CFG_INT4_MODE     = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        KIND_ACT    = 1'b0,
        KIND_WEIGHT = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [1:0]        row;
        logic [BYTE_W-1:0] wbyte;
        logic              lo_ok;
        logic              hi_ok;
        logic              final_byte;
    } stage_t;

    function automatic logic signed [NIB_W-1:0] decode_nibble(input logic [3:0] code,
                                                              input logic       int4);
        logic signed [NIB_W-1:0] val;
        if (int4)
        begin
            val = {code[3], code};
        end
        else
        begin
            val = $signed({1'b0, code}) - 5'sd1;
        end
        return val;
    endfunction

endpackage

/* hw/rtl/pngv_item_if.sv */
// ---------------------------------------------------------------------------
// Item request channel
// Carries activation loads and packed weight bytes into the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pngv_item_if;
    import pngv_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [INDEX_W-1:0] act_index;
    logic signed [ACT_W-1:0] act_value;
    logic [BYTE_W-1:0]  weight_byte;

    modport source (output valid, output kind, output act_index, output act_value,
                    output weight_byte, input ready);
    modport sink   (input valid, input kind, input act_index, input act_value,
                    input weight_byte, output ready);
endinterface

/* hw/rtl/pngv_result_if.sv */
// ---------------------------------------------------------------------------
// Result request channel
// Carries one row sum per request out of the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pngv_result_if;
    import pngv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        row_index;
    logic signed [SUM_W-1:0] row_sum;
    logic                    last_of_group;

    modport source (output valid, output row_index, output row_sum,
                    output last_of_group, input ready);
    modport sink   (input valid, input row_index, input row_sum,
                    input last_of_group, output ready);
endinterface

/* hw/rtl/pngv_cfg_if.sv */
// ---------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pngv_cfg_if;
    import pngv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/packed_nibble_gemv_unit.sv */
// ---------------------------------------------------------------------------
// Packed nibble matrix-vector unit
// Int4 or code-1 weights times a stored vector of signed activation bytes.
// ---------------------------------------------------------------------------
// Usage: load the activation vector through the item channel with kind = 0,
// then stream weight bytes with kind = 1 in tile order (per group of four
// rows, per block of four inputs, two bytes per row). The cfg channel writes
// input_blocks, output_groups and int4_mode; it is always ready and is meant
// to be written while the block is idle.
// Throughput: one item per cycle while ready. The activations sit in an even
// and an odd bank, so one read of both banks serves both nibbles of a byte.
// A group's four sums reach the output buffer as its last byte leaves the
// multiply stage, and go out on the result channel one per cycle when ready.
// A group yields four requests per eight or more weight bytes, so the
// stream is never slowed while the receiver keeps up. When the receiver
// stalls, the last byte of the next group waits in the multiply stage and the
// item channel drops ready until the previous group has drained.
// Reset clears the accumulators, the tile counters and the configuration to
// its defaults; the activation banks are not cleared and must be loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module packed_nibble_gemv_unit #(
    parameter int MAX_INPUTS = 8192,
    parameter int MAX_GROUPS = 4096
) (
    input logic           clk,
    input logic           rst_n,
    pngv_item_if.sink     item,
    pngv_result_if.source result,
    pngv_cfg_if.sink      cfg
);
    import pngv_pkg::*;

    localparam int BANK_DEPTH = (MAX_INPUTS + 1) / 2;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int GRP_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    logic [BLOCKS_W-1:0] input_blocks_reg;
    logic [GROUPS_W-1:0] output_groups_reg;
    logic                int4_mode_reg;

    logic signed [ACT_W-1:0] bank_even [BANK_DEPTH];
    logic signed [ACT_W-1:0] bank_odd  [BANK_DEPTH];
    logic signed [ACT_W-1:0] rd_even_reg;
    logic signed [ACT_W-1:0] rd_odd_reg;

    logic [2:0]             byte_reg;
    logic [BLOCK_CNT_W-1:0] block_reg;
    logic [GRP_W-1:0]       group_reg;

    logic                   s1_valid_reg;
    stage_t                 s1_reg;
    stage_t                 s1_next;
    logic [GRP_W-1:0]       s1_group_reg;

    logic signed [SUM_W-1:0] acc_reg [4];
    logic signed [SUM_W-1:0] obuf_reg [4];
    logic [GRP_W-1:0]        obuf_group_reg;
    logic                    busy_reg;
    logic [1:0]              drain_reg;

    logic                    in_accept;
    logic                    w_accept;
    logic                    a_accept;
    logic                    out_accept;
    logic                    buf_can_load;
    logic                    hold;
    logic                    load;
    logic [BLOCKS_W-1:0]     blk_last;
    logic [31:0]             grp_last;
    logic                    block_end;
    logic                    group_end;
    logic [INDEX_W-1:0]      pos;
    logic [31:0]             rd_addr_wide;
    logic [31:0]             wr_addr_wide;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    wr_ok;
    logic signed [ACT_W-1:0] act_lo;
    logic signed [ACT_W-1:0] act_hi;
    logic signed [NIB_W-1:0] nib_lo;
    logic signed [NIB_W-1:0] nib_hi;
    logic signed [PROD_W-1:0] prod_lo;
    logic signed [PROD_W-1:0] prod_hi;
    logic signed [PAIR_W-1:0] prod_sum;
    logic signed [SUM_W-1:0]  acc_sum;
    logic [31:0]              row_wide;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_blocks_reg  <= BLOCKS_W'(1);
            output_groups_reg <= GROUPS_W'(1);
            int4_mode_reg     <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_INPUT_BLOCKS:  input_blocks_reg  <= cfg.data[BLOCKS_W-1:0];
                CFG_OUTPUT_GROUPS: output_groups_reg <= cfg.data[GROUPS_W-1:0];
                CFG_INT4_MODE:     int4_mode_reg     <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (input_blocks_reg == '0)
        begin
            blk_last = '0;
        end
        else if (input_blocks_reg > BLOCKS_W'(BLOCK_LIMIT))
        begin
            blk_last = BLOCKS_W'(BLOCK_LIMIT - 1);
        end
        else
        begin
            blk_last = input_blocks_reg - 1'b1;
        end
        if (output_groups_reg == '0)
        begin
            grp_last = '0;
        end
        else if (32'(output_groups_reg) > 32'(MAX_GROUPS))
        begin
            grp_last = 32'(MAX_GROUPS - 1);
        end
        else
        begin
            grp_last = 32'(output_groups_reg) - 32'd1;
        end
    end

    assign block_end    = ({1'b0, block_reg} >= blk_last);
    assign group_end    = (32'(group_reg) >= grp_last);
    assign out_accept   = result.valid && result.ready;
    assign buf_can_load = !busy_reg || (out_accept && drain_reg == 2'd3);
    assign hold         = s1_valid_reg && s1_reg.final_byte && !buf_can_load;
    assign load         = s1_valid_reg && s1_reg.final_byte && !hold;
    assign item.ready   = !hold;
    assign in_accept    = item.valid && item.ready;
    assign w_accept     = in_accept && (item.kind == KIND_WEIGHT);
    assign a_accept     = in_accept && (item.kind == KIND_ACT);

    assign pos          = {block_reg, byte_reg[0], 1'b0};
    assign rd_addr_wide = 32'({block_reg, byte_reg[0]});
    assign rd_addr      = rd_addr_wide[ADDR_W-1:0];
    assign wr_addr_wide = 32'(item.act_index >> 1);
    assign wr_addr      = wr_addr_wide[ADDR_W-1:0];
    assign wr_ok        = 32'(item.act_index) < 32'(MAX_INPUTS);

    always_comb
    begin
        s1_next.row        = byte_reg[2:1];
        s1_next.wbyte      = item.weight_byte;
        s1_next.lo_ok      = 32'(pos) < 32'(MAX_INPUTS);
        s1_next.hi_ok      = (32'(pos) + 32'd1) < 32'(MAX_INPUTS);
        s1_next.final_byte = (byte_reg == 3'd7) && block_end;
    end

    always_ff @(posedge clk)
    begin
        if (a_accept && wr_ok)
        begin
            if (item.act_index[0])
            begin
                bank_odd[wr_addr] <= item.act_value;
            end
            else
            begin
                bank_even[wr_addr] <= item.act_value;
            end
        end
        if (w_accept)
        begin
            rd_even_reg  <= bank_even[rd_addr];
            rd_odd_reg   <= bank_odd[rd_addr];
            s1_reg       <= s1_next;
            s1_group_reg <= group_reg;
        end
        if (load)
        begin
            obuf_reg[0]    <= acc_reg[0];
            obuf_reg[1]    <= acc_reg[1];
            obuf_reg[2]    <= acc_reg[2];
            obuf_reg[3]    <= acc_sum;
            obuf_group_reg <= s1_group_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg     <= '0;
            block_reg    <= '0;
            group_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (!hold)
            begin
                s1_valid_reg <= w_accept;
            end
            if (w_accept)
            begin
                byte_reg <= byte_reg + 3'd1;
                if (byte_reg == 3'd7)
                begin
                    if (block_end)
                    begin
                        block_reg <= '0;
                        group_reg <= group_end ? '0 : group_reg + 1'b1;
                    end
                    else
                    begin
                        block_reg <= block_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign act_lo   = s1_reg.lo_ok ? rd_even_reg : '0;
    assign act_hi   = s1_reg.hi_ok ? rd_odd_reg : '0;
    assign nib_lo   = decode_nibble(s1_reg.wbyte[3:0], int4_mode_reg);
    assign nib_hi   = decode_nibble(s1_reg.wbyte[7:4], int4_mode_reg);
    assign prod_lo  = act_lo * nib_lo;
    assign prod_hi  = act_hi * nib_hi;
    assign prod_sum = PAIR_W'(prod_lo) + PAIR_W'(prod_hi);
    assign acc_sum  = acc_reg[s1_reg.row] + SUM_W'(prod_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                acc_reg[r] <= '0;
            end
            busy_reg  <= 1'b0;
            drain_reg <= '0;
        end
        else
        begin
            if (s1_valid_reg && !hold)
            begin
                if (s1_reg.final_byte)
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        acc_reg[r] <= '0;
                    end
                end
                else
                begin
                    acc_reg[s1_reg.row] <= acc_sum;
                end
            end
            if (load)
            begin
                busy_reg  <= 1'b1;
                drain_reg <= '0;
            end
            else if (out_accept)
            begin
                drain_reg <= drain_reg + 2'd1;
                if (drain_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign row_wide             = (32'(obuf_group_reg) << 2) | 32'(drain_reg);
    assign result.valid         = busy_reg;
    assign result.row_index     = row_wide[ROW_W-1:0];
    assign result.row_sum       = obuf_reg[drain_reg];
    assign result.last_of_group = (drain_reg == 2'd3);

    `ASSERT_ALWAYS(a_stall_only_on_final, clk, rst_n, item.ready || (s1_valid_reg && s1_reg.final_byte))
    `ASSERT_NEXT(a_held_final_stays, clk, rst_n, hold, s1_valid_reg && s1_reg.final_byte)
    `ASSERT_NEXT(a_load_starts_drain, clk, rst_n, load, busy_reg && drain_reg == 2'd0)
    `ASSERT_NEXT(a_drain_ends, clk, rst_n, out_accept && drain_reg == 2'd3 && !load, !busy_reg)

endmodule

/* dv/tb_packed_nibble_gemv_unit.sv */
// ---------------------------------------------------------------------------
// Packed nibble GEMV unit testbench
// Loads activation vectors, streams packed weight bytes in tile order under
// several block, group and decode settings, and compares every row sum with
// a cycle-free prediction kept inside the bench. Both channels idle and
// stall at random, and rows of extreme codes run once at each decode mode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_packed_nibble_gemv_unit;
    import pngv_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int ACT_DEPTH     = 8192;
    localparam int GROUP_LIMIT   = 4096;
    localparam int SETTLE_CYCLES = 6;
    localparam int ITEM_TARGET   = 220;

    typedef struct {
        logic [ROW_W-1:0]        row_index;
        logic signed [SUM_W-1:0] row_sum;
        logic                    last_of_group;
    } row_result_t;

    logic clk;
    logic rst_n;

    pngv_item_if   item_ch ();
    pngv_result_if result_ch ();
    pngv_cfg_if    cfg_ch ();

    packed_nibble_gemv_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    logic signed [ACT_W-1:0] act_copy [ACT_DEPTH];
    logic signed [SUM_W-1:0] row_acc [4] = '{default: '0};
    int unsigned             tile_byte = 0;
    int unsigned             block_idx = 0;
    int unsigned             group_idx = 0;
    logic [BLOCKS_W-1:0]     blocks_reg = 1;
    logic [GROUPS_W-1:0]     groups_reg = 1;
    logic                    int4_reg = 1'b0;
    row_result_t             expected_rows [$];
    int                      items_sent = 0;
    int                      mismatch_count = 0;
    bit                      steady_flow = 1'b0;

    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(24, 8);
    endfunction

    function automatic int nibble_value(input logic [3:0] code);
        if (int4_reg)
            return code[3] ? int'(code) - 16 : int'(code);
        return int'(code) - 1;
    endfunction

    function automatic int unsigned blocks_limit();
        if (blocks_reg == 0)
            return 1;
        return (blocks_reg > BLOCK_LIMIT) ? BLOCK_LIMIT : blocks_reg;
    endfunction

    function automatic int unsigned groups_limit();
        if (groups_reg == 0)
            return 1;
        return (groups_reg > GROUP_LIMIT) ? GROUP_LIMIT : groups_reg;
    endfunction

    task automatic accumulate_weight_byte(input logic [BYTE_W-1:0] wbyte);
        int unsigned row;
        int unsigned pos;
        int          prod;
        row_result_t entry;
        row = tile_byte >> 1;
        pos = block_idx * 4 + (tile_byte % 2) * 2;
        prod = int'(act_copy[pos]) * nibble_value(wbyte[3:0])
             + int'(act_copy[pos + 1]) * nibble_value(wbyte[7:4]);
        row_acc[row] = row_acc[row] + SUM_W'(prod);
        if (tile_byte < 7)
            tile_byte++;
        else
        begin
            tile_byte = 0;
            if (block_idx + 1 < blocks_limit())
                block_idx++;
            else
            begin
                block_idx = 0;
                for (int r = 0; r < 4; r++)
                begin
                    entry.row_index     = ROW_W'(group_idx * 4 + r);
                    entry.row_sum       = row_acc[r];
                    entry.last_of_group = (r == 3);
                    expected_rows.push_back(entry);
                    row_acc[r] = '0;
                end
                group_idx = (group_idx + 1 < groups_limit()) ? group_idx + 1 : 0;
            end
        end
    endtask

    task automatic send_item(input item_kind_t kind, input logic [INDEX_W-1:0] idx,
                             input logic signed [ACT_W-1:0] value,
                             input logic [BYTE_W-1:0] wbyte);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= kind;
        item_ch.act_index   <= idx;
        item_ch.act_value   <= value;
        item_ch.weight_byte <= wbyte;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (kind == KIND_ACT)
            act_copy[idx] = value;
        else
            accumulate_weight_byte(wbyte);
        items_sent++;
    endtask

    task automatic load_act(input logic [INDEX_W-1:0] idx, input logic signed [ACT_W-1:0] value);
        send_item(KIND_ACT, idx, value, BYTE_W'($urandom));
    endtask

    task automatic send_weight(input logic [BYTE_W-1:0] wbyte);
        send_item(KIND_WEIGHT, INDEX_W'($urandom), ACT_W'($urandom), wbyte);
    endtask

    task automatic pause_for_results();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rows.size() != 0);
    endtask

    task automatic settle();
        pause_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] blocks,
                             input logic [CFG_DATA_W-1:0] groups,
                             input logic [CFG_DATA_W-1:0] mode, input bit touch_unused);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int                    count;
        regs  = '{CFG_INPUT_BLOCKS, CFG_OUTPUT_GROUPS, CFG_INT4_MODE, CFG_UNUSED_INDEX};
        vals  = '{blocks, groups, mode, CFG_DATA_W'($urandom)};
        count = touch_unused ? 4 : 3;
        settle();
        for (int i = 0; i < count; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            case (regs[i])
                CFG_INPUT_BLOCKS:  blocks_reg = vals[i][BLOCKS_W-1:0];
                CFG_OUTPUT_GROUPS: groups_reg = vals[i][GROUPS_W-1:0];
                CFG_INT4_MODE:     int4_reg   = vals[i][0];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Rows 0 to 2 use fixed extreme codes when requested; row 3 stays random.
    task automatic stream_groups(input int n_groups, input int load_pct, input bit extreme_rows);
        int unsigned       span;
        int unsigned       row;
        logic [BYTE_W-1:0] wbyte;
        span = blocks_limit() * 4;
        for (int g = 0; g < n_groups; g++)
        begin
            for (int k = 0; k < blocks_limit() * 8; k++)
            begin
                if ($urandom_range(99) < load_pct)
                begin
                    if ($urandom_range(99) < 80)
                        load_act(INDEX_W'($urandom_range(span - 1)), ACT_W'($urandom));
                    else
                        load_act(INDEX_W'($urandom_range(ACT_DEPTH - 1)), ACT_W'($urandom));
                end
                if ($urandom_range(199) == 0)
                    pause_for_results();
                row   = (k % 8) >> 1;
                wbyte = BYTE_W'($urandom);
                if (extreme_rows)
                begin
                    case (row)
                        0: wbyte = 8'h88;
                        1: wbyte = 8'h77;
                        2: wbyte = 8'hFF;
                        default: ;
                    endcase
                end
                send_weight(wbyte);
            end
        end
    endtask

    task automatic test_reset_defaults();
        logic signed [ACT_W-1:0] acts [4];
        logic [BYTE_W-1:0]       codes [8];
        acts  = '{8'h80, 8'h7F, 8'hFF, 8'h00};
        codes = '{8'h00, 8'hFF, 8'h21, 8'h12, 8'h10, 8'h02, 8'hEF, 8'h3C};
        for (int i = 0; i < 4; i++)
            load_act(INDEX_W'(i), acts[i]);
        for (int i = 0; i < 8; i++)
            send_weight(codes[i]);
    endtask

    task automatic test_int4_extremes();
        logic [BYTE_W-1:0] codes [8];
        codes = '{8'h88, 8'h77, 8'h80, 8'h08, 8'hF0, 8'h0F, 8'h97, 8'h69};
        load_act(13'h1FFF, 8'h7F);
        configure(1, 2, 1, 1'b0);
        for (int i = 0; i < 8; i++)
            send_weight(codes[i]);
    endtask

    task automatic test_config_limits();
        configure(13'h1000, 13'h0000, 13'h1FFE, 1'b1);
        stream_groups(2, 10, 1'b0);
        configure(13'h0001, 13'h1FFF, 13'h0001, 1'b0);
        stream_groups(3, 10, 1'b0);
    endtask

    task automatic test_random_phases();
        int phase;
        phase = 0;
        for (int i = 0; i < 16; i++)
            load_act(INDEX_W'(i), ACT_W'($urandom));
        while (items_sent < ITEM_TARGET)
        begin
            steady_flow = (phase % 4 == 3);
            configure(CFG_DATA_W'(($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1)),
                      CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(8191)
                                                           : $urandom_range(6)),
                      CFG_DATA_W'($urandom), $urandom_range(3) == 0);
            stream_groups($urandom_range(3, 1), 8, 1'b0);
            phase++;
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_extreme_rows();
        for (int i = 0; i < 8; i++)
            load_act(INDEX_W'(i), 8'h80);
        configure(2, CFG_DATA_W'(GROUP_LIMIT), 1, 1'b0);
        stream_groups(1, 0, 1'b1);
        configure(2, 1, 0, 1'b0);
        stream_groups(1, 0, 1'b1);
    endtask

    task automatic check_row_result();
        row_result_t want;
        if (expected_rows.size() == 0)
        begin
            $error("row_index: expected none, got %0d", result_ch.row_index);
            mismatch_count++;
        end
        else
        begin
            want = expected_rows.pop_front();
            if (result_ch.row_index !== want.row_index)
            begin
                $error("row_index: expected %0d, got %0d", want.row_index, result_ch.row_index);
                mismatch_count++;
            end
            if (result_ch.row_sum !== want.row_sum)
            begin
                $error("row_sum: expected %0d, got %0d", want.row_sum, result_ch.row_sum);
                mismatch_count++;
            end
            if (result_ch.last_of_group !== want.last_of_group)
            begin
                $error("last_of_group: expected %0b, got %0b", want.last_of_group,
                       result_ch.last_of_group);
                mismatch_count++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : row_sum_checker
        int stall;
        stall = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                check_row_result();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.kind        <= KIND_ACT;
        item_ch.act_index   <= '0;
        item_ch.act_value   <= '0;
        item_ch.weight_byte <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_INPUT_BLOCKS;
        cfg_ch.data         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_int4_extremes();
        test_config_limits();
        test_random_phases();
        test_extreme_rows();
        settle();
        if (mismatch_count == 0)
            $display("PASS packed_nibble_gemv_unit");
        else
            $display("FAIL packed_nibble_gemv_unit");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("FAIL packed_nibble_gemv_unit");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/pngv_pkg.sv
hw/rtl/pngv_item_if.sv
hw/rtl/pngv_result_if.sv
hw/rtl/pngv_cfg_if.sv
hw/rtl/packed_nibble_gemv_unit.sv
dv/tb_packed_nibble_gemv_unit.sv
